@@ hw/rtl/plst_pkg.sv @@
package plst_pkg;

  typedef logic signed [31:0] value_t;

  // Command codes
  localparam logic [2:0] ACT_INSERT   = 3'd0;
  localparam logic [2:0] ACT_DELETE   = 3'd1;
  localparam logic [2:0] ACT_LOCATE   = 3'd2;
  localparam logic [2:0] ACT_RETRIEVE = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  // Broadcast control for every cell of the chain
  typedef struct packed {
    cell_op_t   op;
    logic [6:0] pos;
    value_t     value;
    logic       scan_load;
    logic       scan_shift;
  } cell_ctl_t;

  typedef struct packed {
    value_t     read_value;
    logic [6:0] found_position;
    logic [6:0] list_length;
    logic [1:0] status;
  } result_t;

endpackage

@@ hw/rtl/plst_cell.sv @@
module plst_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  plst_pkg::cell_ctl_t ctl,
  input  plst_pkg::value_t   left_entry,
  input  plst_pkg::value_t   right_entry,
  input  plst_pkg::value_t   right_scan,
  output plst_pkg::value_t   entry,
  output plst_pkg::value_t   scan
);

  plst_pkg::value_t entry_r, entry_nxt;
  plst_pkg::value_t scan_r, scan_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      plst_pkg::CELL_INS: begin
        // take the left neighbor above the insert point, the new value at it
        if (INDEX > int'(ctl.pos)) begin
          entry_nxt = left_entry;
        end else if (INDEX == int'(ctl.pos)) begin
          entry_nxt = ctl.value;
        end
      end
      plst_pkg::CELL_DEL: begin
        // close the gap from the right
        if (INDEX >= int'(ctl.pos)) begin
          entry_nxt = right_entry;
        end
      end
      plst_pkg::CELL_HOLD: begin
        entry_nxt = entry_r;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_comb begin
    if (ctl.scan_load) begin
      scan_nxt = entry_r;
    end else if (ctl.scan_shift) begin
      scan_nxt = right_scan;
    end else begin
      scan_nxt = scan_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    scan_r  <= scan_nxt;
  end

  assign entry = entry_r;
  assign scan  = scan_r;

endmodule

@@ hw/rtl/positional_list_engine.sv @@
// Channel   Direction  Ports                                              Handshake
// in        input      in_action, in_item_value, in_position              in_valid / in_stall
// out       output     out_read_value, out_found_position,                out_valid / out_stall
//                      out_list_length, out_status
//
// Insert, delete, clear, unknown codes, rejected commands and a locate on an empty list
// finish in the cycle the item is accepted; the result is registered.
// Retrieve and locate otherwise run a scan: the scan row of the cell chain shifts one
// cell per cycle toward cell 0, where it is compared.
// No item is accepted while a scan runs.
// Reset (rst_n low at a clock edge) empties the list; stored values are not cleared.
// A stalled result is held in the output register while one more item is accepted;
// its result waits in a pending register, and input stalls until that one drains.
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_action,
  input  logic signed [31:0]  in_item_value,
  input  logic [6:0]          in_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_read_value,
  output logic [6:0]          out_found_position,
  output logic [6:0]          out_list_length,
  output logic [1:0]          out_status
);

  localparam int CW = $clog2(CAPACITY + 1);  // length counter
  localparam int IW = $clog2(CAPACITY);      // scan position
  localparam int WW = (CW > 7) ? CW : 7;     // compare width for positions

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       cnt_r, cnt_nxt;
  logic                is_loc_r, is_loc_nxt;
  plst_pkg::value_t    val_r, val_nxt;
  logic [6:0]          pos_r, pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  plst_pkg::result_t   out_res_r, out_res_nxt;
  plst_pkg::result_t   pend_res_r, pend_res_nxt;

  plst_pkg::cell_ctl_t cell_ctl;
  plst_pkg::value_t    entry_w [CAPACITY];
  plst_pkg::value_t    scan_w  [CAPACITY];
  plst_pkg::value_t    left_w  [CAPACITY];
  plst_pkg::value_t    right_w [CAPACITY];
  plst_pkg::value_t    rscan_w [CAPACITY];

  logic                in_fire;
  logic                out_take;
  logic                done;
  plst_pkg::result_t   res;
  logic [WW-1:0]       pos_w;
  logic [WW-1:0]       count_w;
  logic                full;

  // ---------------------------------------------------------------- cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i] = '0;
    end else begin : g_body
      assign left_w[i] = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w[i] = '0;
      assign rscan_w[i] = '0;
    end else begin : g_inner
      assign right_w[i] = entry_w[i+1];
      assign rscan_w[i] = scan_w[i+1];
    end
    plst_cell #(.INDEX(i)) u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .left_entry  (left_w[i]),
      .right_entry (right_w[i]),
      .right_scan  (rscan_w[i]),
      .entry       (entry_w[i]),
      .scan        (scan_w[i])
    );
  end

  // ---------------------------------------------------------------- handshakes
  // Hold input while a scan runs or a result is parked in the pending register.
  assign in_stall = (state_r == S_SCAN) | pend_valid_r;
  assign in_fire  = in_valid & ~in_stall;
  assign out_take = out_valid_r & ~out_stall;

  assign pos_w   = WW'(in_position);
  assign count_w = WW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));

  // ---------------------------------------------------------------- command control
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cnt_nxt    = cnt_r;
    is_loc_nxt = is_loc_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    done       = 1'b0;
    res        = '0;
    cell_ctl            = '0;
    cell_ctl.op         = plst_pkg::CELL_HOLD;
    cell_ctl.pos        = in_position;
    cell_ctl.value      = in_item_value;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            plst_pkg::ACT_INSERT: begin
              done = 1'b1;
              if (pos_w > count_w) begin
                res.status = plst_pkg::ST_RANGE;
              end else if (full) begin
                res.status = plst_pkg::ST_FULL;
              end else begin
                cell_ctl.op = plst_pkg::CELL_INS;
                count_nxt   = count_r + CW'(1);
              end
            end
            plst_pkg::ACT_DELETE: begin
              done = 1'b1;
              if (pos_w >= count_w) begin
                res.status = plst_pkg::ST_RANGE;
              end else begin
                cell_ctl.op = plst_pkg::CELL_DEL;
                count_nxt   = count_r - CW'(1);
              end
            end
            plst_pkg::ACT_LOCATE: begin
              if (count_r == '0) begin
                // empty list: report the length, which is zero
                done = 1'b1;
              end else begin
                cell_ctl.scan_load = 1'b1;
                state_nxt  = S_SCAN;
                cnt_nxt    = '0;
                is_loc_nxt = 1'b1;
                val_nxt    = in_item_value;
                pos_nxt    = in_position;
              end
            end
            plst_pkg::ACT_RETRIEVE: begin
              if (pos_w >= count_w) begin
                done       = 1'b1;
                res.status = plst_pkg::ST_RANGE;
              end else begin
                cell_ctl.scan_load = 1'b1;
                state_nxt  = S_SCAN;
                cnt_nxt    = '0;
                is_loc_nxt = 1'b0;
                val_nxt    = in_item_value;
                pos_nxt    = in_position;
              end
            end
            plst_pkg::ACT_CLEAR: begin
              // entries past the length are never read, so only the length drops
              done      = 1'b1;
              count_nxt = '0;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Cell 0 of the scan row holds the entry at position cnt_r.
        if (is_loc_r) begin
          if (scan_w[0] == val_r) begin
            done = 1'b1;
            res.found_position = 7'(cnt_r);
          end else if ((CW'(cnt_r) + CW'(1)) == count_r) begin
            done = 1'b1;
            res.found_position = 7'(count_r);
          end else begin
            cell_ctl.scan_shift = 1'b1;
            cnt_nxt = cnt_r + IW'(1);
          end
        end else begin
          if (WW'(cnt_r) == WW'(pos_r)) begin
            done = 1'b1;
            res.read_value = scan_w[0];
          end else begin
            cell_ctl.scan_shift = 1'b1;
            cnt_nxt = cnt_r + IW'(1);
          end
        end
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.list_length = 7'(count_nxt);
  end

  // ---------------------------------------------------------------- result registers
  always_comb begin
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    out_res_nxt    = out_res_r;
    pend_res_nxt   = pend_res_r;
    if (done) begin
      if (!out_valid_r || out_take) begin
        out_res_nxt   = res;
        out_valid_nxt = 1'b1;
      end else begin
        // park the result behind the stalled one
        pend_res_nxt   = res;
        pend_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      if (pend_valid_r) begin
        out_res_nxt    = pend_res_r;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    is_loc_r   <= is_loc_nxt;
    val_r      <= val_nxt;
    pos_r      <= pos_nxt;
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_res_r.read_value;
  assign out_found_position = out_res_r.found_position;
  assign out_list_length    = out_res_r.list_length;
  assign out_status         = out_res_r.status;

  // ---------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending result without a result in the output register");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_ctl.op == plst_pkg::CELL_INS) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctl.scan_load |=> (state_r == S_SCAN) && (cnt_r == '0))
    else $error("scan load did not start a scan at position zero");

  a_scan_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(count_r))
    else $error("list length changed during a scan");

endmodule

@@ tb/positional_list_engine_test.sv @@
module positional_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LIST_CAPACITY   = 64;
  localparam int     CLK_PERIOD      = 12;
  localparam int     RESET_CYCLES    = 9;
  localparam int     RANDOM_COMMANDS = 1300;
  localparam int     HOLD_OFF_CYCLES = 300;
  // Longest scan is a locate over a full list, plus the output stage.
  localparam int     SCAN_DRAIN      = LIST_CAPACITY + 8;
  localparam longint CYCLE_LIMIT     = 600000;

  // Codes 5 to 7 are not commands; the block must ignore them.
  localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;

  localparam plst_pkg::value_t VALUE_POOL [8] = '{
    32'sd0, -32'sd1, 32'sd1, 32'sh7fffffff,
    32'sh80000000, 32'sh55555555, 32'shaaaaaaaa, 32'sd100
  };

  typedef enum int {PH_GROW, PH_SHRINK, PH_FILL, PH_MIXED, PH_NOISE} phase_kind_t;

  // One row of the directed table. Where typed is set, reply is the literal expectation;
  // otherwise the list predictor supplies it.
  typedef struct packed {
    logic [2:0]        action;
    plst_pkg::value_t  item_value;
    logic [6:0]        position;
    logic              typed;
    plst_pkg::result_t reply;
  } list_cmd_row_t;

  localparam int DIRECTED_COUNT = 25;

  // reply fields: read_value, found_position, list_length, status
  localparam list_cmd_row_t DIRECTED_CMDS [DIRECTED_COUNT] = '{
    // empty list: retrieve, delete and an insert past the end are out of range, locate returns length
    '{plst_pkg::ACT_RETRIEVE, 32'sd0, 7'd0, 1'b1, '{32'sd0, 7'd0, 7'd0, plst_pkg::ST_RANGE}},
    '{plst_pkg::ACT_DELETE, 32'sd0, 7'd0, 1'b1, '{32'sd0, 7'd0, 7'd0, plst_pkg::ST_RANGE}},
    '{plst_pkg::ACT_LOCATE, 32'sd5, 7'd0, 1'b1, '{32'sd0, 7'd0, 7'd0, plst_pkg::ST_OK}},
    '{plst_pkg::ACT_INSERT, 32'sd1, 7'd1, 1'b1, '{32'sd0, 7'd0, 7'd0, plst_pkg::ST_RANGE}},
    // build a short list from the value extremes, at head, head and tail
    '{plst_pkg::ACT_INSERT, 32'sh7fffffff, 7'd0, 1'b1, '{32'sd0, 7'd0, 7'd1, plst_pkg::ST_OK}},
    '{plst_pkg::ACT_INSERT, 32'sh80000000, 7'd0, 1'b1, '{32'sd0, 7'd0, 7'd2, plst_pkg::ST_OK}},
    '{plst_pkg::ACT_INSERT, 32'sd0, 7'd2, 1'b1, '{32'sd0, 7'd0, 7'd3, plst_pkg::ST_OK}},
    '{plst_pkg::ACT_INSERT, -32'sd1, 7'd1, 1'b0, '0},
    '{plst_pkg::ACT_RETRIEVE, 32'sd0, 7'd0, 1'b0, '0},
    '{plst_pkg::ACT_RETRIEVE, 32'sd0, 7'd3, 1'b0, '0},
    '{plst_pkg::ACT_RETRIEVE, 32'sd0, 7'd4, 1'b1, '{32'sd0, 7'd0, 7'd4, plst_pkg::ST_RANGE}},
    '{plst_pkg::ACT_LOCATE, 32'sh7fffffff, 7'd0, 1'b0, '0},
    '{plst_pkg::ACT_LOCATE, 32'sd12345, 7'd0, 1'b0, '0},
    // duplicate value at the tail: locate must report the first copy
    '{plst_pkg::ACT_INSERT, -32'sd1, 7'd4, 1'b0, '0},
    '{plst_pkg::ACT_LOCATE, -32'sd1, 7'd0, 1'b0, '0},
    '{plst_pkg::ACT_DELETE, 32'sd0, 7'd4, 1'b0, '0},
    '{plst_pkg::ACT_DELETE, 32'sd0, 7'd0, 1'b0, '0},
    // largest position code against a length of three
    '{plst_pkg::ACT_RETRIEVE, 32'sd0, 7'd127, 1'b1, '{32'sd0, 7'd0, 7'd3, plst_pkg::ST_RANGE}},
    '{plst_pkg::ACT_INSERT, 32'sd9, 7'd127, 1'b1, '{32'sd0, 7'd0, 7'd3, plst_pkg::ST_RANGE}},
    '{plst_pkg::ACT_DELETE, 32'sd0, 7'd127, 1'b1, '{32'sd0, 7'd0, 7'd3, plst_pkg::ST_RANGE}},
    // unused codes leave the list alone
    '{ACT_FIRST_UNUSED, -32'sd1, 7'd127, 1'b1, '{32'sd0, 7'd0, 7'd3, plst_pkg::ST_OK}},
    '{ACT_FIRST_UNUSED + 3'd1, 32'sd0, 7'd0, 1'b1, '{32'sd0, 7'd0, 7'd3, plst_pkg::ST_OK}},
    '{ACT_LAST_UNUSED, 32'sh7fffffff, 7'd64, 1'b1, '{32'sd0, 7'd0, 7'd3, plst_pkg::ST_OK}},
    '{plst_pkg::ACT_CLEAR, 32'sd0, 7'd0, 1'b1, '{32'sd0, 7'd0, 7'd0, plst_pkg::ST_OK}},
    '{plst_pkg::ACT_RETRIEVE, 32'sd0, 7'd0, 1'b1, '{32'sd0, 7'd0, 7'd0, plst_pkg::ST_RANGE}}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_action;
  logic signed [31:0] in_item_value;
  logic [6:0]         in_position;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_read_value;
  logic [6:0]         out_found_position;
  logic [6:0]         out_list_length;
  logic [1:0]         out_status;

  // Predictor state: a private copy of the list.
  plst_pkg::value_t  list_store [LIST_CAPACITY];
  int                list_count;
  plst_pkg::result_t list_replies_due [$];

  logic   idle_enabled = 1'b1;
  logic   hold_request = 1'b0;
  longint cycle_count = 0;
  int     mismatch_count = 0;
  int     replies_checked = 0;
  int     commands_sent = 0;
  int     random_sent = 0;
  int     full_rejects = 0;
  int     range_rejects = 0;
  int     locate_hits = 0;
  int     ignored_codes = 0;
  int     peak_length = 0;
  int     holdoffs_done = 0;

  positional_list_engine #(
    .CAPACITY(LIST_CAPACITY)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_item_value     (in_item_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_found_position(out_found_position),
    .out_list_length   (out_list_length),
    .out_status        (out_status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Apply one command to the private list and return the reply the block owes.
  function automatic plst_pkg::result_t apply_list_command(logic [2:0] act,
                                                           plst_pkg::value_t val,
                                                           logic [6:0] pos);
    plst_pkg::result_t r;
    int                i;
    r = '0;
    r.status = plst_pkg::ST_OK;
    case (act)
      plst_pkg::ACT_INSERT: begin
        // position check comes before the full check
        if (pos > list_count) begin
          r.status = plst_pkg::ST_RANGE;
        end else if (list_count >= LIST_CAPACITY) begin
          r.status = plst_pkg::ST_FULL;
        end else begin
          for (i = list_count; i > pos; i--) list_store[i] = list_store[i - 1];
          list_store[pos] = val;
          list_count++;
        end
      end
      plst_pkg::ACT_DELETE: begin
        if (pos >= list_count) begin
          r.status = plst_pkg::ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_count; i++) list_store[i] = list_store[i + 1];
          list_count--;
        end
      end
      plst_pkg::ACT_LOCATE: begin
        // walk from the tail so the first match wins
        r.found_position = 7'(list_count);
        for (i = list_count - 1; i >= 0; i--) begin
          if (list_store[i] == val) r.found_position = 7'(i);
        end
      end
      plst_pkg::ACT_RETRIEVE: begin
        if (pos >= list_count) r.status = plst_pkg::ST_RANGE;
        else r.read_value = list_store[pos];
      end
      plst_pkg::ACT_CLEAR: begin
        for (i = 0; i < LIST_CAPACITY; i++) list_store[i] = '0;
        list_count = 0;
      end
      default: ;
    endcase
    r.list_length = 7'(list_count);
    return r;
  endfunction

  function automatic plst_pkg::value_t pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return VALUE_POOL[$urandom_range(7)];
    if (roll < 45 && list_count > 0) return list_store[$urandom_range(list_count - 1)];
    return plst_pkg::value_t'($urandom);
  endfunction

  // Offer one item, wait until the block takes it, then record the reply it owes.
  // Handshake state is read at the falling edge, where nothing is in motion.
  task automatic drive_command(logic [2:0] act, plst_pkg::value_t val, logic [6:0] pos,
                               logic typed, plst_pkg::result_t typed_reply);
    int                gap;
    plst_pkg::result_t predicted;
    gap = 0;
    if (idle_enabled && $urandom_range(99) < 16) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_item_value <= val;
    in_position   <= pos;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    predicted = apply_list_command(act, val, pos);
    list_replies_due.push_back(typed ? typed_reply : predicted);
    commands_sent++;
    if (predicted.status == plst_pkg::ST_FULL) full_rejects++;
    if (predicted.status == plst_pkg::ST_RANGE) range_rejects++;
    if (act == plst_pkg::ACT_LOCATE && predicted.found_position < predicted.list_length)
      locate_hits++;
    if (act > plst_pkg::ACT_CLEAR) ignored_codes++;
    if (list_count > peak_length) peak_length = list_count;
  endtask

  // Build one random command shaped by the phase, then drive it.
  task automatic issue_random(phase_kind_t kind);
    logic [2:0]       act;
    logic [6:0]       pos;
    plst_pkg::value_t val;
    int               roll;
    roll = $urandom_range(99);
    val = pick_value();
    case (kind)
      PH_GROW: begin
        act = roll < 65 ? plst_pkg::ACT_INSERT :
              roll < 75 ? plst_pkg::ACT_DELETE :
              roll < 88 ? plst_pkg::ACT_LOCATE : plst_pkg::ACT_RETRIEVE;
      end
      PH_SHRINK: begin
        act = roll < 60 ? plst_pkg::ACT_DELETE :
              roll < 72 ? plst_pkg::ACT_INSERT :
              roll < 86 ? plst_pkg::ACT_LOCATE : plst_pkg::ACT_RETRIEVE;
      end
      PH_FILL: begin
        act = (list_count < LIST_CAPACITY || roll < 60) ? plst_pkg::ACT_INSERT :
              roll < 80 ? plst_pkg::ACT_RETRIEVE : plst_pkg::ACT_LOCATE;
      end
      PH_MIXED: begin
        act = roll < 2 ? plst_pkg::ACT_CLEAR :
              3'($urandom_range(plst_pkg::ACT_INSERT, plst_pkg::ACT_RETRIEVE));
      end
      default: begin
        act = 3'($urandom_range(plst_pkg::ACT_INSERT, ACT_LAST_UNUSED));
      end
    endcase

    // Mostly legal positions, with the ends favored and a few past the end.
    roll = $urandom_range(99);
    if (kind == PH_NOISE || roll < 8) begin
      pos = 7'($urandom_range(list_count, 127));
      if (kind == PH_NOISE) pos = 7'($urandom_range(127));
    end else if (act == plst_pkg::ACT_INSERT) begin
      pos = roll < 18 ? 7'(list_count) : roll < 28 ? 7'd0 : 7'($urandom_range(list_count));
    end else if (list_count == 0) begin
      pos = 7'd0;
    end else begin
      pos = roll < 18 ? 7'(list_count - 1) : roll < 28 ? 7'd0 :
            7'($urandom_range(list_count - 1));
    end

    // Search for stored values half of the time so locate finds hits.
    if (act == plst_pkg::ACT_LOCATE && list_count > 0 && $urandom_range(1) == 1) begin
      val = list_store[$urandom_range(list_count - 1)];
    end
    drive_command(act, val, pos, 1'b0, '0);
    random_sent++;
  endtask

  task automatic check_field(string name, logic signed [32:0] want,
                             logic signed [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random stalls, a quiet stretch, and long hold-offs on request so
  // the output and pending registers fill and the input stalls.
  initial begin : result_sink
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        holdoffs_done++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else if (idle_enabled && $urandom_range(99) < 16) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each reply that will be taken at the coming rising edge.
  always @(negedge clk) begin : reply_check
    plst_pkg::result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (list_replies_due.size() == 0) begin
        $error("reply with no command outstanding");
        mismatch_count++;
      end else begin
        want = list_replies_due.pop_front();
        check_field("read_value", want.read_value, out_read_value);
        check_field("found_position", want.found_position, out_found_position);
        check_field("list_length", want.list_length, out_list_length);
        check_field("status", want.status, out_status);
        replies_checked++;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    phase_kind_t kind;
    int          phase_len;
    int          roll;
    int          n;
    int          first_phases;

    // Drive every input to a known value from time zero, and hold reset.
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= plst_pkg::ACT_INSERT;
    in_item_value <= '0;
    in_position   <= '0;
    list_count = 0;
    for (n = 0; n < LIST_CAPACITY; n++) list_store[n] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: walk every row once.
    for (n = 0; n < DIRECTED_COUNT; n++) begin
      drive_command(DIRECTED_CMDS[n].action, DIRECTED_CMDS[n].item_value,
                    DIRECTED_CMDS[n].position, DIRECTED_CMDS[n].typed,
                    DIRECTED_CMDS[n].reply);
    end

    // Random phases. Open with fill and drain so the full case is hit early,
    // then pick phases at random.
    first_phases = 0;
    while (random_sent < RANDOM_COMMANDS) begin
      roll = $urandom_range(99);
      if (first_phases == 0) kind = PH_FILL;
      else if (first_phases == 1) kind = PH_SHRINK;
      else if (roll < 22) kind = PH_GROW;
      else if (roll < 37) kind = PH_SHRINK;
      else if (roll < 50) kind = PH_FILL;
      else if (roll < 85) kind = PH_MIXED;
      else kind = PH_NOISE;
      first_phases++;
      phase_len = kind == PH_FILL ? LIST_CAPACITY - list_count + $urandom_range(6, 16) :
                  kind == PH_SHRINK && first_phases == 2 ? LIST_CAPACITY + 8 :
                  $urandom_range(20, 80);
      for (n = 0; n < phase_len && random_sent < RANDOM_COMMANDS; n++) begin
        // Drop all idling for a stretch in the middle of the run.
        idle_enabled = !(random_sent >= 500 && random_sent < 720);
        // Ask the receiver for a long hold-off while items keep coming.
        if (random_sent == 150 || random_sent == 1000) hold_request = 1'b1;
        issue_random(kind);
      end
    end
    idle_enabled = 1'b1;
    in_valid <= 1'b0;

    // Wait for every owed reply, then give a slow scan time to show a stray one.
    while (list_replies_due.size() != 0) @(posedge clk);
    repeat (SCAN_DRAIN) @(posedge clk);

    $display("Run sent %0d commands (%0d directed, %0d random), %0d replies checked.",
             commands_sent, DIRECTED_COUNT, random_sent, replies_checked);
    $display("Peak length %0d, %0d full and %0d range rejects, %0d locate hits, %0d %s %0d",
             peak_length, full_rejects, range_rejects, locate_hits, ignored_codes,
             "unused codes, long hold-offs:", holdoffs_done);
    if (mismatch_count == 0 && list_replies_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
